@@ hdl/ibt_pkg.sv @@
// Package for the interval basis table: default sizes, request codes, reset values and a byte popcount.
// Used by the top level and the testbench; has no dependencies of its own.
`default_nettype none

package ibt_pkg;

    localparam int VEC_BITS_DEF    = 64;
    localparam int MAX_ENTRIES_DEF = 64;

    localparam logic [6:0] ACTIVE_VARS_RST = 7'd64;

    typedef enum logic [1:0] {
        REQ_CLEAR   = 2'd0,
        REQ_APPEND  = 2'd1,
        REQ_PATTERN = 2'd2,
        REQ_CONTAIN = 2'd3
    } req_t;

    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 0; k < 8; k++)
        begin
            n = n + 4'(v[k]);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

@@ hdl/ibt_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module ibt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ hdl/interval_basis_table.sv @@
// Interval basis table: a RAM of (must-be-one, must-be-zero) pairs with append and tests.
// From accept to done: clear goes straight to ST_RESP; append runs the dimension popcount (one
// byte of each vector a cycle); a test scans each entry then ST_LAST, skipped on an empty table.
// The RAM read port delivers one entry a cycle; the next start is taken the cycle after done.
// Results are strobed for one cycle on done and cannot be stalled. Reset empties the table
// and sets active_vars to 64; the RAM contents are not cleared.
`default_nettype none

module interval_basis_table #(
    parameter int VEC_BITS    = ibt_pkg::VEC_BITS_DEF,
    parameter int MAX_ENTRIES = ibt_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire ibt_pkg::req_t     req_type,
    input  wire logic [63:0]       ones_vec,
    input  wire logic [63:0]       zeros_vec,
    output logic                   done,
    output logic [63:0]            hit_mask,
    output logic                   any_hit,
    output logic [6:0]             hit_count,
    output logic signed [7:0]      interval_dim,
    output logic                   status,
    output logic [6:0]             entry_total,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [6:0]        cfg_data
);

    import ibt_pkg::*;

    localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int NCH  = (VEC_BITS + 7) / 8;
    localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PADW = NCH * 8;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIM  = 5'b00010,
        ST_SCAN = 5'b00100,
        ST_LAST = 5'b01000,
        ST_RESP = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [6:0]           av_reg;
    logic                 rd_vld_reg;
    logic [AW-1:0]        rd_idx_reg;
    logic [AW-1:0]        scan_idx_reg, scan_idx_next;
    logic [CHW-1:0]       ch_reg, ch_next;
    logic [7:0]           pop_reg, pop_next;
    req_t                 req_reg;
    logic [VEC_BITS-1:0]  a_reg, b_reg;
    logic [MAX_ENTRIES-1:0] mask_reg, mask_next;
    logic [CW-1:0]        hcnt_reg, hcnt_next;
    logic [7:0]           dim_reg, dim_next;
    logic                 status_reg, status_next;

    logic                    wr_en;
    logic [2*VEC_BITS-1:0]   rd_data;
    logic [VEC_BITS-1:0]     sa, sb;
    logic                    hit;
    logic [6:0]              n_eff;
    logic [VEC_BITS-1:0]     vmask;
    logic [PADW-1:0]         a_pad, b_pad;
    logic [7:0]              a_chunk, b_chunk;
    logic [7:0]              pop_sum;
    logic                    accept;

    // Tests and appends never overlap: busy holds off the next request until done,
    // so a read never meets a write to the same entry.
    ibt_ram #(
        .WIDTH(2 * VEC_BITS),
        .DEPTH(MAX_ENTRIES)
    ) u_store (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(count_reg[AW-1:0]),
        .wr_data({a_reg, b_reg}),
        .rd_addr(scan_idx_reg),
        .rd_data(rd_data)
    );

    assign accept = start && (state_reg == ST_IDLE);

    assign sa = rd_data[2*VEC_BITS-1:VEC_BITS];
    assign sb = rd_data[VEC_BITS-1:0];

    always_comb
    begin
        if (req_reg == REQ_PATTERN)
        begin
            hit = ((sa & a_reg) == sa) && ((sb & a_reg) == '0);
        end
        else
        begin
            hit = ((a_reg & sa) == sa) && ((b_reg & sb) == sb);
        end
    end

    assign n_eff = (av_reg > 7'(VEC_BITS)) ? 7'(VEC_BITS) : av_reg;

    always_comb
    begin
        for (int j = 0; j < VEC_BITS; j++)
        begin
            vmask[j] = (7'(j) < n_eff);
        end
    end

    assign a_pad   = PADW'(a_reg & vmask);
    assign b_pad   = PADW'(b_reg & vmask);
    assign a_chunk = a_pad[{ch_reg, 3'b000} +: 8];
    assign b_chunk = b_pad[{ch_reg, 3'b000} +: 8];
    assign pop_sum = pop_reg + 8'(pop8(a_chunk)) + 8'(pop8(b_chunk));

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        ch_next       = ch_reg;
        pop_next      = pop_reg;
        mask_next     = mask_reg;
        hcnt_next     = hcnt_reg;
        dim_next      = dim_reg;
        status_next   = status_reg;
        wr_en         = 1'b0;

        // The entry read last cycle is judged here, whatever state the scan has reached.
        if (rd_vld_reg && hit)
        begin
            mask_next[rd_idx_reg] = 1'b1;
            hcnt_next             = hcnt_reg + CW'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    mask_next     = '0;
                    hcnt_next     = '0;
                    dim_next      = '0;
                    status_next   = 1'b0;
                    pop_next      = '0;
                    ch_next       = '0;
                    scan_idx_next = '0;
                    case (req_type)
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                            state_next = ST_RESP;
                        end
                        REQ_APPEND:
                        begin
                            state_next = ST_DIM;
                        end
                        default:
                        begin
                            state_next = (count_reg == '0) ? ST_RESP : ST_SCAN;
                        end
                    endcase
                end
            end
            ST_DIM:
            begin
                pop_next = pop_sum;
                ch_next  = ch_reg + CHW'(1);
                if (ch_reg == CHW'(NCH - 1))
                begin
                    dim_next = 8'(n_eff) - pop_sum;
                    if (count_reg < CW'(MAX_ENTRIES))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        status_next = 1'b1;
                    end
                    state_next = ST_RESP;
                end
            end
            ST_SCAN:
            begin
                scan_idx_next = scan_idx_reg + AW'(1);
                if (CW'(scan_idx_reg) == count_reg - CW'(1))
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            av_reg     <= ACTIVE_VARS_RST;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_vld_reg <= (state_reg == ST_SCAN);
            if (cfg_valid && cfg_ready)
            begin
                av_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_type;
            a_reg   <= ones_vec[VEC_BITS-1:0];
            b_reg   <= zeros_vec[VEC_BITS-1:0];
        end
        rd_idx_reg   <= scan_idx_reg;
        scan_idx_reg <= scan_idx_next;
        ch_reg       <= ch_next;
        pop_reg      <= pop_next;
        mask_reg     <= mask_next;
        hcnt_reg     <= hcnt_next;
        dim_reg      <= dim_next;
        status_reg   <= status_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = (state_reg == ST_RESP);
    assign cfg_ready    = 1'b1;
    assign hit_mask     = 64'(mask_reg);
    assign any_hit      = |mask_reg;
    assign hit_count    = 7'(hcnt_reg);
    assign interval_dim = dim_reg;
    assign status       = status_reg;
    assign entry_total  = 7'(count_reg);

    // The table never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count beyond table depth");

    // A dropped append is only reported with a full table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (count_reg == CW'(MAX_ENTRIES)))
        else $error("drop flagged with room in the table");

    // Each accepted request is followed by a busy period, and done is a single beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("request accepted without going busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    // The RAM is written only while an append finishes, never during a scan.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_DIM) && !rd_vld_reg)
        else $error("table write outside an append");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the interval basis table: directed and random request streams,
// a scoreboard class that predicts every result, and a watchdog. Depends on ibt_pkg and the RTL.

module tb_top;
    import ibt_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int PHASE_ITEMS  = 150;
    localparam int TABLE_DEPTH  = MAX_ENTRIES_DEF;

    typedef struct {
        logic [63:0]       mask;
        logic              any;
        logic [6:0]        count;
        logic signed [7:0] dim;
        logic              stat;
        logic [6:0]        total;
    } table_result_t;

    class interval_table_model;
        logic [63:0]   ones_mem [TABLE_DEPTH];
        logic [63:0]   zeros_mem [TABLE_DEPTH];
        int unsigned   held;
        logic [6:0]    vars_used;
        table_result_t awaited [$];
        int unsigned   failures;

        function new();
            held      = 0;
            vars_used = ACTIVE_VARS_RST;
            failures  = 0;
        endfunction

        function void set_active_vars(logic [6:0] v);
            vars_used = v;
        endfunction

        function logic signed [7:0] dimension(logic [63:0] a, logic [63:0] b);
            int          n;
            logic [63:0] m;
            n = vars_used;
            if (n > 64)
            begin
                n = 64;
            end
            if (n == 0)
            begin
                return 8'sd0;
            end
            m = (n == 64) ? {64{1'b1}} : ((64'd1 << n) - 64'd1);
            return 8'(n - $countones(a & m) - $countones(b & m));
        endfunction

        function void note_request(req_t req, logic [63:0] a, logic [63:0] b);
            table_result_t r;
            r = '{mask: '0, any: 1'b0, count: '0, dim: '0, stat: 1'b0, total: '0};
            case (req)
                REQ_CLEAR:
                begin
                    held = 0;
                end
                REQ_APPEND:
                begin
                    r.dim = dimension(a, b);
                    if (held >= TABLE_DEPTH)
                    begin
                        r.stat = 1'b1;
                    end
                    else
                    begin
                        ones_mem[held]  = a;
                        zeros_mem[held] = b;
                        held++;
                    end
                end
                default:
                begin
                    for (int i = 0; i < held; i++)
                    begin
                        if (req == REQ_PATTERN)
                        begin
                            r.mask[i] = ((ones_mem[i] & a) == ones_mem[i])
                                        && ((zeros_mem[i] & a) == 64'd0);
                        end
                        else
                        begin
                            r.mask[i] = ((a & ones_mem[i]) == ones_mem[i])
                                        && ((b & zeros_mem[i]) == zeros_mem[i]);
                        end
                    end
                end
            endcase
            r.any   = |r.mask;
            r.count = 7'($countones(r.mask));
            r.total = 7'(held);
            awaited.push_back(r);
        endfunction

        function void check_result(table_result_t got);
            table_result_t want;
            if (awaited.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("result with nothing pending: mask %h total %0d", got.mask, got.total);
                end
                return;
            end
            want = awaited.pop_front();
            if (got.mask !== want.mask || got.any !== want.any || got.count !== want.count
                || got.dim !== want.dim || got.stat !== want.stat || got.total !== want.total)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("expected mask %h any %0b count %0d dim %0d status %0b total %0d",
                             want.mask, want.any, want.count, want.dim, want.stat, want.total);
                    $display("  actual mask %h any %0b count %0d dim %0d status %0b total %0d",
                             got.mask, got.any, got.count, got.dim, got.stat, got.total);
                end
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    req_t              req_type = REQ_CLEAR;
    logic [63:0]       ones_vec = '0;
    logic [63:0]       zeros_vec = '0;
    logic              done;
    logic [63:0]       hit_mask;
    logic              any_hit;
    logic [6:0]        hit_count;
    logic signed [7:0] interval_dim;
    logic              status;
    logic [6:0]        entry_total;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [6:0]        cfg_data = ACTIVE_VARS_RST;

    interval_table_model table_model = new();

    int unsigned results_seen = 0;
    int unsigned issued       = 0;
    bit          no_gaps      = 1'b0;

    // The driver's own view of what the table holds, used to aim tests at stored entries.
    logic [63:0] held_ones [$];
    logic [63:0] held_zeros [$];

    interval_basis_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .ones_vec     (ones_vec),
        .zeros_vec    (zeros_vec),
        .done         (done),
        .hit_mask     (hit_mask),
        .any_hit      (any_hit),
        .hit_count    (hit_count),
        .interval_dim (interval_dim),
        .status       (status),
        .entry_total  (entry_total),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Results are taken before requests so a same-edge beat keeps its order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                table_model.check_result('{hit_mask, any_hit, hit_count, interval_dim,
                                           status, entry_total});
                results_seen <= results_seen + 1;
            end
            if (start && !busy)
            begin
                table_model.note_request(req_type, ones_vec, zeros_vec);
            end
            if (cfg_valid && cfg_ready)
            begin
                table_model.set_active_vars(cfg_data);
            end
        end
    end

    initial
    begin
        int unsigned stall_cycles;
        stall_cycles = 0;
        @(posedge rst_n);
        while (stall_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
        end
        $display("interval_basis_table: mismatch");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_gaps)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] rand_vec();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return {$urandom, $urandom};
            default: return {$urandom, $urandom} & {$urandom, $urandom}
                            & {$urandom, $urandom} & {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_request(req_t req, logic [63:0] a, logic [63:0] b);
        int unsigned gap;
        start     <= 1'b1;
        req_type  <= req;
        ones_vec  <= a;
        zeros_vec <= b;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        issued++;
        if (req == REQ_CLEAR)
        begin
            held_ones.delete();
            held_zeros.delete();
        end
        else if (req == REQ_APPEND && held_ones.size() < TABLE_DEPTH)
        begin
            held_ones.push_back(a);
            held_zeros.push_back(b);
        end
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (results_seen != issued)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_active_vars(logic [6:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
        begin
            @(posedge clk);
        end
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
    endtask

    // A test aimed at a stored entry, widened so that it still covers it, or pure noise.
    task automatic probe_table();
        int unsigned j;
        req_t        req;
        logic [63:0] a;
        logic [63:0] b;
        req = $urandom_range(0, 1) ? REQ_PATTERN : REQ_CONTAIN;
        a   = rand_vec();
        b   = rand_vec();
        if (held_ones.size() != 0 && $urandom_range(0, 3) != 0)
        begin
            j = $urandom_range(0, held_ones.size() - 1);
            if (req == REQ_PATTERN)
            begin
                a = (held_ones[j] | rand_vec()) & ~held_zeros[j];
            end
            else
            begin
                a = held_ones[j] | rand_vec();
                b = held_zeros[j] | rand_vec();
            end
        end
        send_request(req, a, b);
    endtask

    task automatic build_and_probe();
        int unsigned fill;
        bit          trivial;
        send_request(REQ_CLEAR, rand_vec(), rand_vec());
        fill    = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 10) : $urandom_range(60, 70);
        trivial = (fill >= 60) && $urandom_range(0, 1);
        for (int k = 0; k < fill; k++)
        begin
            if (trivial)
            begin
                send_request(REQ_APPEND, '0, '0);
            end
            else
            begin
                send_request(REQ_APPEND, rand_vec(), rand_vec());
            end
            if ($urandom_range(0, 4) == 0)
            begin
                probe_table();
            end
        end
        repeat ($urandom_range(1, 5)) probe_table();
    endtask

    initial
    begin
        logic [6:0]  settings [8];
        int unsigned target;
        settings = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd32, 7'($urandom_range(1, 64)), 7'd7};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, dimension extremes, both tests, clear.
        send_request(REQ_PATTERN, '1, '0);
        send_request(REQ_CONTAIN, '1, '1);
        send_request(REQ_APPEND, '0, '0);
        send_request(REQ_APPEND, '1, '1);
        send_request(REQ_APPEND, '1, '0);
        send_request(REQ_APPEND, 64'h0000_0000_0000_00FF, 64'h0000_0000_0000_FF00);
        send_request(REQ_APPEND, 64'h8000_0000_0000_0001, 64'h0000_0000_0000_0002);
        send_request(REQ_PATTERN, '0, '1);
        send_request(REQ_PATTERN, '1, '0);
        send_request(REQ_PATTERN, 64'h0000_0000_0000_00FF, '1);
        send_request(REQ_PATTERN, 64'h8000_0000_0000_0001, '0);
        send_request(REQ_CONTAIN, '1, '1);
        send_request(REQ_CONTAIN, '0, '0);
        send_request(REQ_CONTAIN, 64'h0000_0000_0000_00FF, 64'h0000_0000_0000_FF00);
        send_request(REQ_CONTAIN, 64'h8000_0000_0000_0001, 64'h0000_0000_0000_0002);
        send_request(REQ_CLEAR, '1, '1);
        send_request(REQ_PATTERN, '0, '0);
        send_request(REQ_CONTAIN, '0, '0);
        send_request(REQ_APPEND, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_request(REQ_CONTAIN, '1, '1);

        for (int p = 0; p < 8; p++)
        begin
            write_active_vars(settings[p]);
            no_gaps = (p % 3 == 2);
            target  = issued + PHASE_ITEMS;
            while (issued < target)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    build_and_probe();
                end
                else
                begin
                    send_request(req_t'($urandom_range(0, 3)), rand_vec(), rand_vec());
                end
            end
        end
        write_active_vars(ACTIVE_VARS_RST);
        send_request(REQ_APPEND, '1, '0);

        drain_results();
        repeat (70) @(posedge clk);
        if (table_model.failures == 0 && table_model.awaited.size() == 0)
        begin
            $display("interval_basis_table: match");
        end
        else
        begin
            $display("interval_basis_table: mismatch");
        end
        $finish;
    end

endmodule
